@@ rtl/core/cpr_pkg.sv @@
// Shared definitions for the clock page replacement block.
// Opcodes, status codes, sequencer states and inter-module structs.
// No dependencies.
`default_nettype none
package cpr_pkg;

  localparam int FRAMES_DEF = 64;

  localparam int OP_W     = 3;
  localparam int IDX_W    = 6;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_ADD     = 3'd0;
  localparam logic [OP_W-1:0] OP_TOUCH   = 3'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 3'd2;
  localparam logic [OP_W-1:0] OP_ASSIGN  = 3'd3;
  localparam logic [OP_W-1:0] OP_PICK    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_CHECK,
    S_RESP
  } state_t;

  // write request into the frame table
  typedef struct packed {
    logic use_we;
    logic use_d;
    logic acc_we;
    logic acc_d;
  } mem_wr_t;

  // sequencer status seen by the top level
  typedef struct packed {
    logic busy;
    logic empty;
    logic full;
  } cpr_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/cpr_frame_mem.sv @@
// Frame table: in-use and accessed bits, one write port, one registered read.
// Depends on cpr_pkg.
`default_nettype none
module cpr_frame_mem #(
  parameter int DEPTH = cpr_pkg::FRAMES_DEF,
  parameter int AW    = $clog2(cpr_pkg::FRAMES_DEF)
) (
  input  wire                   clk,
  input  cpr_pkg::mem_wr_t      wr,
  input  wire  [AW-1:0]         waddr,
  input  wire  [AW-1:0]         raddr,
  output logic                  rd_use,
  output logic                  rd_acc
);

  logic use_mem [DEPTH];
  logic acc_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.use_we) begin
      use_mem[waddr] <= wr.use_d;
    end
    if (wr.acc_we) begin
      acc_mem[waddr] <= wr.acc_d;
    end
    rd_use <= use_mem[raddr];
    rd_acc <= acc_mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/core/cpr_step_unit.sv @@
// Shared increment / compare / wrap unit used by the sequencer's execute and check steps.
// Depends on nothing but its parameter.
`default_nettype none
module cpr_step_unit #(
  parameter int XW = 7
) (
  input  wire  [XW-1:0] opnd,
  input  wire  [XW-1:0] bound,
  input  wire           inc,
  output logic          lt,
  output logic [XW-1:0] wrap
);

  logic [XW:0] sum;

  always_comb begin
    sum  = {1'b0, opnd} + (XW+1)'(inc);
    lt   = (sum < {1'b0, bound});
    wrap = lt ? sum[XW-1:0] : '0;
  end

endmodule
`default_nettype wire

@@ rtl/core/cpr_ctrl.sv @@
// Sequencer for the clock page replacement block: decode, table walk, result register.
// Depends on cpr_pkg; drives cpr_frame_mem and cpr_step_unit.
`default_nettype none
module cpr_ctrl #(
  parameter int FRAMES = cpr_pkg::FRAMES_DEF,
  parameter int AW     = $clog2(cpr_pkg::FRAMES_DEF),
  parameter int CW     = $clog2(cpr_pkg::FRAMES_DEF + 1),
  parameter int XW     = 7
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [cpr_pkg::OP_W-1:0]         in_op,
  input  wire  [cpr_pkg::IDX_W-1:0]        in_idx,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [cpr_pkg::IDX_W-1:0]        out_chosen,
  output logic [cpr_pkg::STATUS_W-1:0]     out_status,
  output cpr_pkg::mem_wr_t                 wr,
  output logic [AW-1:0]                    waddr,
  output logic [AW-1:0]                    raddr,
  input  wire                              rd_use,
  input  wire                              rd_acc,
  output logic [XW-1:0]                    u_opnd,
  output logic [XW-1:0]                    u_bound,
  output logic                             u_inc,
  input  wire                              u_lt,
  input  wire  [XW-1:0]                    u_wrap,
  output cpr_pkg::cpr_stat_t               stat
);

  cpr_pkg::state_t state_r, state_nxt;

  logic [cpr_pkg::OP_W-1:0]     op_r, op_nxt;
  logic [cpr_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic [AW-1:0]                hand_r, hand_nxt;
  logic [AW-1:0]                h_r, h_nxt;
  logic [cpr_pkg::IDX_W-1:0]    res_chosen_r, res_chosen_nxt;
  logic [cpr_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [cpr_pkg::IDX_W-1:0]    out_chosen_r, out_chosen_nxt;
  logic [cpr_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;

  logic [XW-1:0] idx_ext;
  logic [XW-1:0] count_ext;
  logic [XW-1:0] hand_ext;
  logic [XW-1:0] h_ext;
  logic          found;
  logic          slot_free;

  assign idx_ext   = XW'(idx_r);
  assign count_ext = XW'(count_r);
  assign hand_ext  = XW'(hand_r);
  assign h_ext     = XW'(h_r);
  assign found     = !rd_use || !rd_acc;
  assign slot_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cpr_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = cpr_pkg::S_EXEC;
        end
      end
      cpr_pkg::S_EXEC: begin
        if (op_r == cpr_pkg::OP_PICK && count_r != '0) begin
          state_nxt = cpr_pkg::S_READ;
        end else begin
          state_nxt = cpr_pkg::S_RESP;
        end
      end
      cpr_pkg::S_READ: begin
        state_nxt = cpr_pkg::S_CHECK;
      end
      cpr_pkg::S_CHECK: begin
        state_nxt = found ? cpr_pkg::S_RESP : cpr_pkg::S_READ;
      end
      cpr_pkg::S_RESP: begin
        if (slot_free) begin
          state_nxt = cpr_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = cpr_pkg::S_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    in_ready       = (state_r == cpr_pkg::S_IDLE);
    wr             = '0;
    waddr          = h_r;
    raddr          = h_r;
    u_opnd         = '0;
    u_bound        = count_ext;
    u_inc          = 1'b0;
    op_nxt         = op_r;
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    hand_nxt       = hand_r;
    h_nxt          = h_r;
    res_chosen_nxt = res_chosen_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_chosen_nxt = out_chosen_r;
    out_status_nxt = out_status_r;

    unique case (state_r)
      cpr_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt  = in_op;
          idx_nxt = in_idx;
        end
      end
      cpr_pkg::S_EXEC: begin
        res_chosen_nxt = '0;
        res_status_nxt = cpr_pkg::ST_OK;
        unique case (op_r)
          cpr_pkg::OP_ADD: begin
            u_opnd  = count_ext;
            u_bound = XW'(FRAMES);
            if (u_lt) begin
              wr.use_we      = 1'b1;
              wr.use_d       = 1'b1;
              wr.acc_we      = 1'b1;
              wr.acc_d       = 1'b0;
              waddr          = count_r[AW-1:0];
              res_chosen_nxt = count_ext[cpr_pkg::IDX_W-1:0];
              count_nxt      = count_r + CW'(1);
            end else begin
              res_status_nxt = cpr_pkg::ST_FULL;
            end
          end
          cpr_pkg::OP_TOUCH, cpr_pkg::OP_RELEASE, cpr_pkg::OP_ASSIGN: begin
            u_opnd = idx_ext;
            waddr  = idx_ext[AW-1:0];
            if (u_lt) begin
              wr.acc_we = 1'b1;
              wr.acc_d  = (op_r == cpr_pkg::OP_TOUCH);
              wr.use_we = (op_r != cpr_pkg::OP_TOUCH);
              wr.use_d  = (op_r == cpr_pkg::OP_ASSIGN);
            end else begin
              res_status_nxt = cpr_pkg::ST_RANGE;
            end
          end
          cpr_pkg::OP_PICK: begin
            // hand at or beyond the count restarts at frame 0
            u_opnd = hand_ext;
            if (count_r == '0) begin
              res_status_nxt = cpr_pkg::ST_EMPTY;
            end else begin
              h_nxt = u_wrap[AW-1:0];
            end
          end
          default: begin
          end
        endcase
      end
      cpr_pkg::S_READ: begin
        raddr = h_r;
      end
      cpr_pkg::S_CHECK: begin
        u_opnd = h_ext;
        u_inc  = 1'b1;
        if (found) begin
          res_chosen_nxt = h_ext[cpr_pkg::IDX_W-1:0];
          hand_nxt       = u_wrap[AW-1:0];
        end else begin
          // second chance: clear the accessed bit and move on
          wr.acc_we = 1'b1;
          wr.acc_d  = 1'b0;
          waddr     = h_r;
          h_nxt     = u_wrap[AW-1:0];
        end
      end
      cpr_pkg::S_RESP: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_chosen_nxt = res_chosen_r;
          out_status_nxt = res_status_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cpr_pkg::S_IDLE;
      count_r     <= '0;
      hand_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      hand_r      <= hand_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    idx_r        <= idx_nxt;
    h_r          <= h_nxt;
    res_chosen_r <= res_chosen_nxt;
    res_status_r <= res_status_nxt;
    out_chosen_r <= out_chosen_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_chosen = out_chosen_r;
  assign out_status = out_status_r;

  assign stat.busy  = (state_r != cpr_pkg::S_IDLE);
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CW'(FRAMES));

endmodule
`default_nettype wire

@@ rtl/core/clock_page_replacement_top.sv @@
// Top level of the second-chance (clock) page replacement victim selector.
// Depends on cpr_pkg, cpr_frame_mem, cpr_step_unit and cpr_ctrl.
//
// One operation per input transfer (add, touch, release, assign, pick), one
// result transfer per operation. Frames are appended in index order and never
// removed, so the frame count doubles as the fill mark of the frame table:
// no entry at or past the count is ever read, and the table needs no clearing
// pass after reset. The block takes one operation at a time. Add, touch,
// release, assign, an unknown code and a pick on an empty table go from the
// execute step straight to the result step, which loads result valid into the
// output register; the next input transfer is taken back in the idle step. A
// pick goes from the execute step through a read step and a check step for
// each frame examined (1 to count+1 frames): each frame costs one read
// of the frame table (registered read) and one pass through the shared
// increment/compare/wrap unit, which also does every range check. A finished
// result sits in the output register, and the next operation is taken while it
// waits; the sequencer only holds in its final step if the output register is
// still occupied.
`default_nettype none
module clock_page_replacement_top #(
  parameter int FRAMES = cpr_pkg::FRAMES_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire  [7:0] in_tdata,   // [5:0] frame_index, [7:6] zero pad
  input  wire  [2:0] in_tuser,   // [2:0] operation
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [7:0] out_tdata,  // [5:0] chosen_frame, [7:6] zero pad
  output logic [1:0] out_tuser   // [1:0] status
);

  localparam int AW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(FRAMES + 1);
  localparam int XW = (CW > cpr_pkg::IDX_W) ? CW : cpr_pkg::IDX_W;

  cpr_pkg::mem_wr_t   wr;
  cpr_pkg::cpr_stat_t stat;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;
  logic               rd_use;
  logic               rd_acc;
  logic [XW-1:0]      u_opnd;
  logic [XW-1:0]      u_bound;
  logic               u_inc;
  logic               u_lt;
  logic [XW-1:0]      u_wrap;
  logic [cpr_pkg::IDX_W-1:0] chosen;

  // frame table, filled in index order behind the frame count
  cpr_frame_mem #(
    .DEPTH (FRAMES),
    .AW    (AW)
  ) u_mem (
    .clk    (clk),
    .wr     (wr),
    .waddr  (waddr),
    .raddr  (raddr),
    .rd_use (rd_use),
    .rd_acc (rd_acc)
  );

  // one adder and comparator shared by the execute and check steps
  cpr_step_unit #(
    .XW (XW)
  ) u_step (
    .opnd  (u_opnd),
    .bound (u_bound),
    .inc   (u_inc),
    .lt    (u_lt),
    .wrap  (u_wrap)
  );

  cpr_ctrl #(
    .FRAMES (FRAMES),
    .AW     (AW),
    .CW     (CW),
    .XW     (XW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (in_tuser),
    .in_idx     (in_tdata[cpr_pkg::IDX_W-1:0]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_chosen (chosen),
    .out_status (out_tuser),
    .wr         (wr),
    .waddr      (waddr),
    .raddr      (raddr),
    .rd_use     (rd_use),
    .rd_acc     (rd_acc),
    .u_opnd     (u_opnd),
    .u_bound    (u_bound),
    .u_inc      (u_inc),
    .u_lt       (u_lt),
    .u_wrap     (u_wrap),
    .stat       (stat)
  );

  assign out_tdata = {2'b00, chosen};

`ifndef SYNTHESIS
  // input is never accepted again in the cycle after an accepted operation
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on back-to-back cycles");

  // any failing status carries a zero frame index
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != cpr_pkg::ST_OK |-> out_tdata == 8'd0)
    else $error("nonzero frame index with failing status");

  // a table-full result implies the frame count is at its limit
  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == cpr_pkg::ST_FULL |-> stat.full)
    else $error("full status while table has room");

  // an empty-table result held while idle implies no frames yet
  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == cpr_pkg::ST_EMPTY && !stat.busy |-> stat.empty)
    else $error("empty status while table holds frames");
`endif

endmodule
`default_nettype wire
